### hdl/afla_pkg.sv
package afla_pkg;

  localparam logic MODE_CLEAR = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  localparam logic [3:0] SCORE_NONE    = 4'd1;
  localparam logic [3:0] SCORE_FIT     = 4'd2;
  localparam logic [3:0] SCORE_ALIGNED = 4'd6;
  localparam logic [3:0] SCORE_EXACT   = 4'd4;

  typedef struct packed {
    logic capture;
    logic scan;
    logic plan;
    logic shift;
    logic wr0;
    logic wr1;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic out_free;
  } status_t;

endpackage

### hdl/afla_req_if.sv
interface afla_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] field_size;
  logic [2:0]  align_log2;

  modport source (output valid, mode, field_size, align_log2, input ready);
  modport sink (input valid, mode, field_size, align_log2, output ready);
endinterface

### hdl/afla_rsp_if.sv
interface afla_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] field_offset;
  logic [15:0] record_size;
  logic        from_hole;
  logic        overflow;

  modport source (output valid, field_offset, record_size, from_hole, overflow, input ready);
  modport sink (input valid, field_offset, record_size, from_hole, overflow, output ready);
endinterface

### hdl/afla_controller.sv
module afla_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output afla_pkg::cmd_t   cmd,
  input  afla_pkg::status_t status
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_PLAN  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WR0   = 7'b0010000,
    S_WR1   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.shift_done) begin
          state_next = S_WR0;
        end
      end
      S_WR0: begin
        cmd.wr0    = 1'b1;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.wr1    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/afla_datapath.sv
module afla_datapath #(
  parameter int MAX_HOLES   = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  afla_pkg::cmd_t    cmd,
  output afla_pkg::status_t status,
  input  logic              req_mode,
  input  logic [15:0]       req_field_size,
  input  logic [2:0]        req_align_log2,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [15:0]       rsp_field_offset,
  output logic [15:0]       rsp_record_size,
  output logic              rsp_from_hole,
  output logic              rsp_overflow
);

  localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam int OB = OFFSET_BITS;
  localparam int EW = ((OB > 16) ? OB : 16) + 2;
  localparam int HW = 2 * OB;
  localparam logic [EW-1:0] LIMIT   = EW'({OB{1'b1}});
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HOLES);

  logic [HW-1:0] hole_mem [MAX_HOLES];
  logic [HW-1:0] rd_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [HW-1:0] wr_data;

  logic          req_mode_q;
  logic [15:0]   req_size_q;
  logic [2:0]    req_align_q;
  logic [CW-1:0] count;
  logic [OB-1:0] lsize;

  logic [CW-1:0] idx;
  logic          pend;
  logic [IW-1:0] ev_idx;
  logic [3:0]    best_score;
  logic [IW-1:0] best_idx;
  logic [OB-1:0] best_hs;
  logic [OB-1:0] best_sp;

  logic [CW-1:0] sh_n;
  logic [CW-1:0] sh_src;
  logic          sh_left;
  logic          sh_pend;
  logic [IW-1:0] sh_dst;

  logic          w0_en;
  logic [IW-1:0] w0_idx;
  logic [HW-1:0] w0_data;
  logic          w1_en;
  logic [IW-1:0] w1_idx;
  logic [HW-1:0] w1_data;

  logic [15:0]   res_offset;
  logic          res_from;
  logic          res_ovf;

  logic [EW-1:0] mask;
  logic [EW-1:0] sz;
  logic          scan_issue;
  logic          shift_issue;

  logic [EW-1:0] ev_hs;
  logic [EW-1:0] ev_he;
  logic [EW-1:0] ev_b;
  logic [EW-1:0] ev_e;
  logic [3:0]    ev_score;

  logic [EW-1:0] p_hs;
  logic [EW-1:0] p_he;
  logic [EW-1:0] p_b;
  logic [EW-1:0] p_e;
  logic          p_front;
  logic          p_tail;
  logic [EW-1:0] p_cur;
  logic [EW-1:0] p_raw;
  logic [EW-1:0] p_off;
  logic          p_clamp;
  logic [EW-1:0] p_end_raw;
  logic [EW-1:0] p_end;
  logic          p_sat;
  logic          p_gap;
  logic [CW-1:0] p_moves;

  assign mask        = (EW'(1) << req_align_q) - EW'(1);
  assign sz          = EW'(req_size_q);
  assign scan_issue  = cmd.scan && (req_mode_q == afla_pkg::MODE_ALLOC) && (idx < count);
  assign shift_issue = cmd.shift && (sh_n != '0);
  assign rd_en       = scan_issue || shift_issue;
  assign rd_addr     = cmd.shift ? sh_src[IW-1:0] : idx[IW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = w0_idx;
    wr_data = w0_data;
    if (cmd.shift && sh_pend) begin
      wr_en   = 1'b1;
      wr_addr = sh_dst;
      wr_data = rd_q;
    end else if (cmd.wr0 && w0_en) begin
      wr_en = 1'b1;
    end else if (cmd.wr1 && w1_en) begin
      wr_en   = 1'b1;
      wr_addr = w1_idx;
      wr_data = w1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hole_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= hole_mem[rd_addr];
    end
  end

  always_comb begin
    ev_hs    = EW'(rd_q[HW-1:OB]);
    ev_he    = ev_hs + EW'(rd_q[OB-1:0]);
    ev_b     = (ev_hs + mask) & ~mask;
    ev_e     = ev_b + sz;
    ev_score = '0;
    if (ev_he >= ev_e) begin
      ev_score = afla_pkg::SCORE_FIT;
      if (ev_b == ev_hs) begin
        ev_score = ev_score + afla_pkg::SCORE_ALIGNED;
      end
      if (ev_e == ev_he) begin
        ev_score = ev_score + afla_pkg::SCORE_EXACT;
      end
    end
  end

  always_comb begin
    p_hs      = EW'(best_hs);
    p_he      = p_hs + EW'(best_sp);
    p_b       = (p_hs + mask) & ~mask;
    p_e       = p_b + sz;
    p_front   = (p_b != p_hs);
    p_tail    = (p_he != p_e);
    p_cur     = EW'(lsize);
    p_raw     = (p_cur + mask) & ~mask;
    p_clamp   = (p_raw > LIMIT);
    p_off     = p_clamp ? LIMIT : p_raw;
    p_end_raw = p_off + sz;
    p_sat     = (p_end_raw > LIMIT);
    p_end     = p_sat ? LIMIT : p_end_raw;
    p_gap     = (p_off != p_cur);
    p_moves   = count - CW'(best_idx) - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode_q  <= req_mode;
      req_size_q  <= req_field_size;
      req_align_q <= req_align_log2;
      idx         <= '0;
    end else if (scan_issue) begin
      idx    <= idx + CW'(1);
      ev_idx <= idx[IW-1:0];
    end

    if (pend && (ev_score > best_score)) begin
      best_idx <= ev_idx;
      best_hs  <= rd_q[HW-1:OB];
      best_sp  <= rd_q[OB-1:0];
    end

    if (shift_issue) begin
      sh_src <= sh_left ? (sh_src + CW'(1)) : (sh_src - CW'(1));
      sh_dst <= sh_left ? (sh_src[IW-1:0] - IW'(1)) : (sh_src[IW-1:0] + IW'(1));
    end

    if (cmd.plan) begin
      sh_left <= 1'b0;
      sh_src  <= count - CW'(1);
      w0_en   <= 1'b0;
      w1_en   <= 1'b0;
      res_ovf <= 1'b0;
      if (req_mode_q == afla_pkg::MODE_CLEAR) begin
        res_offset <= '0;
        res_from   <= 1'b0;
      end else if (best_score > afla_pkg::SCORE_NONE) begin
        res_offset <= 16'(p_b);
        res_from   <= 1'b1;
        w0_idx     <= best_idx;
        w1_idx     <= best_idx + IW'(1);
        w1_data    <= {OB'(p_e), OB'(p_he - p_e)};
        if (!p_front && !p_tail) begin
          sh_left <= 1'b1;
          sh_src  <= CW'(best_idx) + CW'(1);
        end else if (p_front != p_tail) begin
          w0_en   <= 1'b1;
          w0_data <= p_front ? {best_hs, OB'(p_b - p_hs)} : {OB'(p_e), OB'(p_he - p_e)};
        end else begin
          w0_en   <= 1'b1;
          w0_data <= {best_hs, OB'(p_b - p_hs)};
          if (count == MAX_CNT) begin
            res_ovf <= 1'b1;
          end else begin
            w1_en <= 1'b1;
          end
        end
      end else begin
        res_offset <= 16'(p_off);
        res_from   <= 1'b0;
        w0_idx     <= count[IW-1:0];
        w0_data    <= {lsize, OB'(p_off - p_cur)};
        w0_en      <= p_gap && (count != MAX_CNT);
        res_ovf    <= p_clamp || p_sat || (p_gap && (count == MAX_CNT));
      end
    end

    if (cmd.load_out) begin
      rsp_field_offset <= res_offset;
      rsp_record_size  <= 16'(EW'(lsize));
      rsp_from_hole    <= res_from;
      rsp_overflow     <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      lsize      <= '0;
      pend       <= 1'b0;
      sh_pend    <= 1'b0;
      sh_n       <= '0;
      best_score <= afla_pkg::SCORE_NONE;
      rsp_valid  <= 1'b0;
    end else begin
      pend    <= scan_issue;
      sh_pend <= shift_issue;

      if (cmd.capture) begin
        best_score <= afla_pkg::SCORE_NONE;
      end else if (pend && (ev_score > best_score)) begin
        best_score <= ev_score;
      end

      if (shift_issue) begin
        sh_n <= sh_n - CW'(1);
      end

      if (cmd.plan) begin
        sh_n <= '0;
        if (req_mode_q == afla_pkg::MODE_CLEAR) begin
          count <= '0;
          lsize <= '0;
        end else if (best_score > afla_pkg::SCORE_NONE) begin
          if (!p_front && !p_tail) begin
            count <= count - CW'(1);
            sh_n  <= p_moves;
          end else if (p_front && p_tail && (count != MAX_CNT)) begin
            count <= count + CW'(1);
            sh_n  <= p_moves;
          end
        end else begin
          lsize <= OB'(p_end);
          if (p_gap && (count != MAX_CNT)) begin
            count <= count + CW'(1);
          end
        end
      end

      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign status.scan_done  = !pend && ((idx == count) || (req_mode_q == afla_pkg::MODE_CLEAR));
  assign status.shift_done = (sh_n == '0) && !sh_pend;
  assign status.out_free   = !rsp_valid;

endmodule

### hdl/aligned_field_layout_allocator_unit.sv
// Field layout allocator for one record, one request at a time.
// The req channel carries mode, field_size and align_log2; mode zero clears the
// layout and mode one places a field. The rsp channel returns field_offset,
// the record_size after the request, from_hole and overflow.
// Both channels move a request when valid and ready are high at a clock edge.
// A request scans the hole table in order, one entry per cycle, through a
// registered memory read, then moves table entries one per cycle to open or
// close a slot. The scan and the entry moves share the one memory read port,
// and the time from acceptance to a valid result grows with the hole count
// and the number of entries moved. The block is ready again in the cycle
// after the result is loaded into the output register.
// The result waits in an output register until rsp.ready is seen; a stalled
// receiver holds the block before it loads the next result, and req.ready is
// high only while no request is in progress.
// Synchronous reset empties the layout: size zero and no holes.

module aligned_field_layout_allocator_unit #(
  parameter int MAX_HOLES   = 16,
  parameter int OFFSET_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  afla_req_if.sink   req,
  afla_rsp_if.source rsp
);

  afla_pkg::cmd_t    cmd;
  afla_pkg::status_t status;

  afla_controller u_afla_controller (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .status    (status)
  );

  afla_datapath #(
    .MAX_HOLES   (MAX_HOLES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_afla_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .req_mode         (req.mode),
    .req_field_size   (req.field_size),
    .req_align_log2   (req.align_log2),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_field_offset (rsp.field_offset),
    .rsp_record_size  (rsp.record_size),
    .rsp_from_hole    (rsp.from_hole),
    .rsp_overflow     (rsp.overflow)
  );

endmodule

### hdl/afla_checker.sv
module afla_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_field_offset,
  input logic [15:0] rsp_record_size,
  input logic        rsp_from_hole,
  input logic        rsp_overflow
);

  // A result stays offered until the receiver takes it.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp.valid dropped before the result was taken");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_field_offset) && $stable(rsp_record_size)
      && $stable(rsp_from_hole) && $stable(rsp_overflow))
    else $error("rsp payload changed while stalled");

  // Once a request is taken, no other request is taken until it is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
    else $error("request taken while another is in progress");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid)
    else $error("result offered right after reset");

endmodule

bind aligned_field_layout_allocator_unit afla_checker u_afla_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_field_offset (rsp.field_offset),
  .rsp_record_size  (rsp.record_size),
  .rsp_from_hole    (rsp.from_hole),
  .rsp_overflow     (rsp.overflow)
);

### bench/tb_aligned_field_layout_allocator_unit.sv
`timescale 1ns / 100ps

module tb_aligned_field_layout_allocator_unit;

  localparam int HOLE_SLOTS     = 16;
  localparam int SIZE_LIMIT     = 65535;
  localparam int SETTLE_CYCLES  = 2 * HOLE_SLOTS + 16;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [15:0] field_offset;
    logic [15:0] record_size;
    logic        from_hole;
    logic        overflow;
  } placement_t;

  logic clk;
  logic rst;

  afla_req_if req ();
  afla_rsp_if rsp ();

  aligned_field_layout_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  int unsigned hole_base [HOLE_SLOTS];
  int unsigned hole_len [HOLE_SLOTS];
  int unsigned hole_total;
  int unsigned layout_end;

  placement_t  expected_placements [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit open_hole(int unsigned pos, int unsigned start, int unsigned span);
    if (hole_total >= HOLE_SLOTS || pos > hole_total) return 1'b0;
    for (int unsigned k = hole_total; k > pos; k--) begin
      hole_base[k] = hole_base[k - 1];
      hole_len[k]  = hole_len[k - 1];
    end
    hole_base[pos] = start;
    hole_len[pos]  = span;
    hole_total++;
    return 1'b1;
  endfunction

  function automatic void close_hole(int unsigned pos);
    if (pos >= hole_total) return;
    for (int unsigned k = pos; k + 1 < hole_total; k++) begin
      hole_base[k] = hole_base[k + 1];
      hole_len[k]  = hole_len[k + 1];
    end
    hole_total--;
  endfunction

  function automatic placement_t place_field(logic mode, logic [15:0] size,
                                             logic [2:0] align_log2);
    placement_t  res;
    int unsigned mask, hs, he, b, e, score, best_score, best, pos, cur, fin;
    res = '0;
    if (mode == afla_pkg::MODE_CLEAR) begin
      hole_total = 0;
      layout_end = 0;
      return res;
    end
    mask = (32'd1 << align_log2) - 1;
    best_score = afla_pkg::SCORE_NONE;
    best = 0;
    for (int unsigned i = 0; i < hole_total; i++) begin
      hs = hole_base[i];
      he = hs + hole_len[i];
      b = (hs + mask) & ~mask;
      e = b + size;
      score = 0;
      if (he >= e) begin
        score = afla_pkg::SCORE_FIT;
        if (b == hs) score += afla_pkg::SCORE_ALIGNED;
        if (e == he) score += afla_pkg::SCORE_EXACT;
      end
      if (score > best_score) begin
        best_score = score;
        best = i;
      end
    end
    if (best_score > afla_pkg::SCORE_NONE) begin
      hs = hole_base[best];
      he = hs + hole_len[best];
      b = (hs + mask) & ~mask;
      e = b + size;
      pos = best;
      close_hole(best);
      if (b != hs) begin
        if (open_hole(pos, hs, b - hs)) pos++;
        else res.overflow = 1'b1;
      end
      if (he != e) begin
        if (!open_hole(pos, e, he - e)) res.overflow = 1'b1;
      end
      res.from_hole = 1'b1;
    end else begin
      cur = layout_end;
      b = (cur + mask) & ~mask;
      if (b > SIZE_LIMIT) begin
        b = SIZE_LIMIT;
        res.overflow = 1'b1;
      end
      if (b != cur) begin
        if (!open_hole(hole_total, cur, b - cur)) res.overflow = 1'b1;
      end
      fin = b + size;
      if (fin > SIZE_LIMIT) begin
        fin = SIZE_LIMIT;
        res.overflow = 1'b1;
      end
      layout_end = fin;
    end
    res.field_offset = 16'(b);
    res.record_size  = 16'(layout_end);
    return res;
  endfunction

  task automatic send_request(input logic mode, input logic [15:0] size,
                              input logic [2:0] align_log2);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= mode;
    req.field_size <= size;
    req.align_log2 <= align_log2;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_placements.push_back(place_field(mode, size, align_log2));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
  endtask

  task automatic test_clear_and_end_growth();
    send_request(afla_pkg::MODE_ALLOC, 16'd3, 3'd0);
    send_request(afla_pkg::MODE_CLEAR, 16'd0, 3'd0);
    send_request(afla_pkg::MODE_ALLOC, 16'd1, 3'd0);
    send_request(afla_pkg::MODE_ALLOC, 16'd4, 3'd2);
    send_request(afla_pkg::MODE_ALLOC, 16'd0, 3'd7);
    // The record is now 128 bytes with two padding holes.
    send_request(afla_pkg::MODE_ALLOC, 16'hFFFF, 3'd0);
    send_request(afla_pkg::MODE_ALLOC, 16'd1, 3'd7);
  endtask

  task automatic test_hole_reuse();
    send_request(afla_pkg::MODE_ALLOC, 16'd2, 3'd1);
    send_request(afla_pkg::MODE_ALLOC, 16'd0, 3'd3);
    send_request(afla_pkg::MODE_ALLOC, 16'd1, 3'd0);
    send_request(afla_pkg::MODE_ALLOC, 16'd112, 3'd4);
    send_request(afla_pkg::MODE_CLEAR, 16'hFFFF, 3'd7);
  endtask

  task automatic test_hole_table_full();
    repeat (HOLE_SLOTS + 2) send_request(afla_pkg::MODE_ALLOC, 16'd1, 3'd4);
    // A split with both leftovers in a full table must lose the tail piece.
    send_request(afla_pkg::MODE_ALLOC, 16'd1, 3'd1);
    wait_for_drain();
  endtask

  task automatic run_random_layouts(int unsigned item_goal);
    int unsigned sent, run_len, kind, idx, mask, pad;
    logic        mode;
    logic [15:0] size;
    logic [2:0]  align_log2;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(9) != 0) begin
        send_request(afla_pkg::MODE_CLEAR, 16'($urandom), 3'($urandom));
        sent++;
      end
      run_len = $urandom_range(32, 3);
      for (int unsigned n = 0; n < run_len; n++) begin
        kind = $urandom_range(99);
        mode = afla_pkg::MODE_ALLOC;
        align_log2 = 3'($urandom_range(7));
        if (kind < 4) begin
          mode = 1'($urandom);
          size = 16'($urandom);
        end else if (kind < 30 && hole_total != 0) begin
          // Aim at a known hole so that exact and aligned fits are frequent.
          idx = $urandom_range(hole_total - 1);
          align_log2 = 3'($urandom_range(3));
          mask = (32'd1 << align_log2) - 1;
          pad = ((hole_base[idx] + mask) & ~mask) - hole_base[idx];
          if (pad <= hole_len[idx]) begin
            size = 16'(hole_len[idx] - pad);
            if ($urandom_range(1) != 0) size = 16'(size - $urandom_range(size));
          end else begin
            size = 16'($urandom_range(8));
          end
        end else if (kind < 92) begin
          size = 16'($urandom_range(24));
        end else if (kind < 97) begin
          size = 16'($urandom_range(4095));
        end else begin
          size = 16'($urandom_range(65535));
        end
        send_request(mode, size, align_log2);
        sent++;
      end
    end
  endtask

  task automatic test_random_back_to_back();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_layouts(375);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct = 55;
    recv_stall_pct = 0;
    run_random_layouts(180);
    wait_for_drain();
    run_random_layouts(195);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 55;
    run_random_layouts(375);
  endtask

  task automatic test_random_mixed_idling();
    send_idle_pct = 9;
    recv_stall_pct = 9;
    run_random_layouts(375);
  endtask

  always @(negedge clk) rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    placement_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_placements.size() == 0) begin
        $error("result with no request pending: field_offset %0d record_size %0d",
               rsp.field_offset, rsp.record_size);
        mismatch_count++;
      end else begin
        want = expected_placements.pop_front();
        if (rsp.field_offset !== want.field_offset) begin
          $error("field_offset: expected %0d, got %0d", want.field_offset, rsp.field_offset);
          mismatch_count++;
        end
        if (rsp.record_size !== want.record_size) begin
          $error("record_size: expected %0d, got %0d", want.record_size, rsp.record_size);
          mismatch_count++;
        end
        if (rsp.from_hole !== want.from_hole) begin
          $error("from_hole: expected %0b, got %0b", want.from_hole, rsp.from_hole);
          mismatch_count++;
        end
        if (rsp.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, rsp.overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_aligned_field_layout_allocator_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = afla_pkg::MODE_CLEAR;
    req.field_size = '0;
    req.align_log2 = '0;
    hole_total = 0;
    layout_end = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clear_and_end_growth();
    test_hole_reuse();
    test_hole_table_full();
    test_random_back_to_back();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_mixed_idling();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_aligned_field_layout_allocator_unit: PASS");
    end else begin
      $display("tb_aligned_field_layout_allocator_unit: FAIL");
    end
    $finish;
  end

endmodule
